// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// lbl: name of the check, prop: property body, msg: error text
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// lbl: name of the check, ante: condition, cons: must hold in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/calu8_pkg.sv =====
// ---------------------------------------------------------------------------
// calu8_pkg
// Operation codes, flag positions and rule codes of the 8-bit ALU.
// ---------------------------------------------------------------------------
package calu8_pkg;

  localparam int MODE_W = 5;
  localparam int DATA_W = 8;
  localparam int FLAG_W = 4;
  localparam int RULE_W = 2 * FLAG_W;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [FLAG_W-1:0] flags_t;
  typedef logic [RULE_W-1:0] rule_t;

  localparam mode_t MODE_AND  = 5'd0;
  localparam mode_t MODE_OR   = 5'd1;
  localparam mode_t MODE_XOR  = 5'd2;
  localparam mode_t MODE_BIT  = 5'd3;
  localparam mode_t MODE_CPL  = 5'd4;
  localparam mode_t MODE_ADD  = 5'd5;
  localparam mode_t MODE_ADC  = 5'd6;
  localparam mode_t MODE_SUB  = 5'd7;
  localparam mode_t MODE_SBC  = 5'd8;
  localparam mode_t MODE_SWAP = 5'd9;
  localparam mode_t MODE_SET  = 5'd10;
  localparam mode_t MODE_RES  = 5'd11;
  localparam mode_t MODE_RL   = 5'd12;
  localparam mode_t MODE_RR   = 5'd13;
  localparam mode_t MODE_SLA  = 5'd14;
  localparam mode_t MODE_SRA  = 5'd15;
  localparam mode_t MODE_SRL  = 5'd16;
  localparam mode_t MODE_RLC  = 5'd17;
  localparam mode_t MODE_RRC  = 5'd18;
  localparam mode_t MODE_SCF  = 5'd19;
  localparam mode_t MODE_CCF  = 5'd20;
  localparam mode_t MODE_DAA  = 5'd21;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // per-flag rule codes
  localparam logic [1:0] RULE_CALC  = 2'd0;
  localparam logic [1:0] RULE_SET   = 2'd1;
  localparam logic [1:0] RULE_RESET = 2'd2;
  localparam logic [1:0] RULE_KEEP  = 2'd3;

  localparam data_t NIBBLE_MASK = 8'h0f;
  localparam data_t DAA_LIMIT   = 8'h99;
  localparam data_t DAA_LO_ADJ  = 8'h06;
  localparam data_t DAA_HI_ADJ  = 8'h60;

  // one bit per flag whose rule field equals code
  function automatic flags_t rule_mask(rule_t rule, logic [1:0] code);
    flags_t m;
    m = '0;
    for (int b = 0; b < FLAG_W; b++) begin
      m[b] = (rule[2*b +: 2] == code);
    end
    return m;
  endfunction

endpackage

// ===== src/calu8_if.sv =====
// ---------------------------------------------------------------------------
// calu8 channel interfaces
// Valid/ready channels for operation items and result items.
// ---------------------------------------------------------------------------
interface calu8_in_if;
  import calu8_pkg::*;

  logic   valid;
  logic   ready;
  mode_t  mode;
  data_t  x;
  data_t  y;
  flags_t flags_in;
  rule_t  flag_rule;

  modport source (output valid, mode, x, y, flags_in, flag_rule, input ready);
  modport sink   (input valid, mode, x, y, flags_in, flag_rule, output ready);
endinterface

interface calu8_out_if;
  import calu8_pkg::*;

  logic   valid;
  logic   ready;
  data_t  result;
  flags_t flags_out;

  modport source (output valid, result, flags_out, input ready);
  modport sink   (input valid, result, flags_out, output ready);
endinterface

// ===== src/cpu_alu8_with_flags.sv =====
// An accepted operation item passes the input register, then the result register, to out_ch.
// Throughput: one item per cycle while out_ch.ready holds; input register, one pass of ALU logic,
// result register. On a stall the result register holds, as does a full input register, and a full
// pipe still takes a new item in the same cycle the result is taken.
// Reset (rst_n low, synchronous) empties both stages; no other state is kept.
// ---------------------------------------------------------------------------
// cpu_alu8_with_flags
// Eight-bit ALU with per-flag rule (computed / set / reset / keep) and DAA.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpu_alu8_with_flags (
  input  logic         clk,
  input  logic         rst_n,
  calu8_in_if.sink     in_ch,
  calu8_out_if.source  out_ch
);
  import calu8_pkg::*;

  // -------------------------------------------------------------------------
  // Handshake: stage 2 (result) frees when empty or taken, stage 1 (input)
  // frees when empty or moving into stage 2.
  // -------------------------------------------------------------------------
  logic s2_take;
  logic s1_take;
  logic in_acc;

  logic   s1_valid_r, s1_valid_nxt;
  mode_t  s1_mode_r,  s1_mode_nxt;
  data_t  s1_x_r,     s1_x_nxt;
  data_t  s1_y_r,     s1_y_nxt;
  flags_t s1_f_r,     s1_f_nxt;
  rule_t  s1_rule_r,  s1_rule_nxt;

  logic   out_valid_r,  out_valid_nxt;
  data_t  out_result_r, out_result_nxt;
  flags_t out_flags_r,  out_flags_nxt;

  assign s2_take = !out_valid_r || out_ch.ready;
  assign s1_take = !s1_valid_r || s2_take;
  assign in_acc  = in_ch.valid && s1_take;

  assign in_ch.ready      = s1_take;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.result    = out_result_r;
  assign out_ch.flags_out = out_flags_r;

  // -------------------------------------------------------------------------
  // ALU datapath on the stage 1 item
  // -------------------------------------------------------------------------
  logic       c_in;
  logic       ci;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic       sub_h, sub_c;
  logic       sbc_h, sbc_c;
  data_t      bit_sel;

  flags_t set_m, keep_m, reset_m;
  data_t  alu_res;
  flags_t calc_f;
  logic   sbc_op;
  flags_t alu_f;

  // DAA
  logic   daa_sub;
  data_t  daa_off;
  logic   daa_c;
  data_t  daa_res;
  flags_t daa_f;

  assign c_in = s1_f_r[FLAG_C];
  assign ci   = (s1_mode_r == MODE_ADC) ? c_in : 1'b0;

  assign add_sum  = {1'b0, s1_x_r} + {1'b0, s1_y_r} + {8'd0, ci};
  assign add_half = {1'b0, s1_x_r[3:0]} + {1'b0, s1_y_r[3:0]} + {4'd0, ci};
  assign sub_h    = s1_y_r[3:0] > s1_x_r[3:0];
  assign sub_c    = s1_y_r > s1_x_r;
  // borrow in is added to the subtrahend before the compare
  assign sbc_h    = ({1'b0, s1_y_r[3:0]} + {4'd0, c_in}) > {1'b0, s1_x_r[3:0]};
  assign sbc_c    = ({1'b0, s1_y_r} + {8'd0, c_in}) > {1'b0, s1_x_r};
  assign bit_sel  = data_t'(1) << s1_y_r[2:0];

  assign set_m   = rule_mask(s1_rule_r, RULE_SET);
  assign keep_m  = rule_mask(s1_rule_r, RULE_KEEP);
  assign reset_m = rule_mask(s1_rule_r, RULE_RESET);

  always_comb begin
    alu_res = '0;
    calc_f  = '0;
    sbc_op  = 1'b0;
    case (s1_mode_r)
      MODE_AND:  alu_res = s1_x_r & s1_y_r;
      MODE_OR:   alu_res = s1_x_r | s1_y_r;
      MODE_XOR:  alu_res = s1_x_r ^ s1_y_r;
      MODE_BIT:  alu_res = s1_x_r & s1_y_r;
      MODE_CPL:  alu_res = ~s1_x_r;
      MODE_ADD, MODE_ADC: begin
        alu_res        = add_sum[7:0];
        calc_f[FLAG_H] = add_half[4];
        calc_f[FLAG_C] = add_sum[8];
      end
      MODE_SUB: begin
        alu_res        = s1_x_r - s1_y_r;
        calc_f[FLAG_H] = sub_h;
        calc_f[FLAG_C] = sub_c;
      end
      MODE_SBC: begin
        alu_res        = s1_x_r - s1_y_r - {7'd0, c_in};
        calc_f[FLAG_H] = sbc_h;
        calc_f[FLAG_C] = sbc_c;
        sbc_op         = 1'b1;
      end
      MODE_SWAP: alu_res = {s1_x_r[3:0], s1_x_r[7:4]};
      MODE_SET:  alu_res = s1_x_r | bit_sel;
      MODE_RES:  alu_res = s1_x_r & ~bit_sel;
      MODE_RL: begin
        alu_res        = {s1_x_r[6:0], c_in};
        calc_f[FLAG_C] = s1_x_r[7];
      end
      MODE_RR: begin
        alu_res        = {c_in, s1_x_r[7:1]};
        calc_f[FLAG_C] = s1_x_r[0];
      end
      MODE_SLA: begin
        alu_res        = {s1_x_r[6:0], 1'b0};
        calc_f[FLAG_C] = s1_x_r[7];
      end
      MODE_SRA: begin
        alu_res        = {s1_x_r[7], s1_x_r[7:1]};
        calc_f[FLAG_C] = s1_x_r[0];
      end
      MODE_SRL: begin
        alu_res        = {1'b0, s1_x_r[7:1]};
        calc_f[FLAG_C] = s1_x_r[0];
      end
      MODE_RLC: begin
        alu_res        = {s1_x_r[6:0], s1_x_r[7]};
        calc_f[FLAG_C] = s1_x_r[7];
      end
      MODE_RRC: begin
        alu_res        = {s1_x_r[0], s1_x_r[7:1]};
        calc_f[FLAG_C] = s1_x_r[0];
      end
      MODE_SCF:  alu_res = '0;
      MODE_CCF:  calc_f[FLAG_C] = !c_in;
      default:   alu_res = '0;  // unused codes and DAA (handled below)
    endcase
  end

  // Flag order: set bits, computed flags, zero, kept flags, reset flags.
  // SBC replaces H and C with its own borrows, before the keep and reset rules apply.
  always_comb begin
    alu_f = set_m;
    if (sbc_op) begin
      alu_f[FLAG_H] = 1'b0;
      alu_f[FLAG_C] = 1'b0;
    end
    alu_f = alu_f | calc_f;
    if (alu_res == '0) begin
      alu_f[FLAG_Z] = 1'b1;
    end
    alu_f = (alu_f & ~keep_m) | (s1_f_r & keep_m);
    alu_f = alu_f & ~reset_m;
  end

  // DAA ignores the rule
  always_comb begin
    daa_sub = s1_f_r[FLAG_N];
    daa_off = '0;
    daa_c   = 1'b0;
    if (s1_f_r[FLAG_H] || (!daa_sub && ((s1_x_r & NIBBLE_MASK) > 8'h09))) begin
      daa_off = daa_off | DAA_LO_ADJ;
    end
    if (s1_f_r[FLAG_C] || (!daa_sub && (s1_x_r > DAA_LIMIT))) begin
      daa_off = daa_off | DAA_HI_ADJ;
      daa_c   = 1'b1;
    end
    daa_res        = daa_sub ? (s1_x_r - daa_off) : (s1_x_r + daa_off);
    daa_f          = '0;
    daa_f[FLAG_C]  = daa_c;
    daa_f[FLAG_N]  = daa_sub;
    daa_f[FLAG_Z]  = (daa_res == '0);
  end

  // -------------------------------------------------------------------------
  // Next-state logic for both stages
  // -------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_mode_nxt  = s1_mode_r;
    s1_x_nxt     = s1_x_r;
    s1_y_nxt     = s1_y_r;
    s1_f_nxt     = s1_f_r;
    s1_rule_nxt  = s1_rule_r;
    if (s1_take) begin
      s1_valid_nxt = in_ch.valid;
    end
    if (in_acc) begin
      s1_mode_nxt = in_ch.mode;
      s1_x_nxt    = in_ch.x;
      s1_y_nxt    = in_ch.y;
      s1_f_nxt    = in_ch.flags_in;
      s1_rule_nxt = in_ch.flag_rule;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_flags_nxt  = out_flags_r;
    if (s2_take) begin
      out_valid_nxt = s1_valid_r;
    end
    if (s2_take && s1_valid_r) begin
      out_result_nxt = (s1_mode_r == MODE_DAA) ? daa_res : alu_res;
      out_flags_nxt  = (s1_mode_r == MODE_DAA) ? daa_f   : alu_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_mode_r    <= s1_mode_nxt;
    s1_x_r       <= s1_x_nxt;
    s1_y_r       <= s1_y_nxt;
    s1_f_r       <= s1_f_nxt;
    s1_rule_r    <= s1_rule_nxt;
    out_result_r <= out_result_nxt;
    out_flags_r  <= out_flags_nxt;
  end

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  // an accepted item lands in the input stage
  `ASSERT_NEXT(a_in_lands, in_ch.valid && in_ch.ready, s1_valid_r, "accepted item lost")
  // an input-stage item moving on becomes a result item
  `ASSERT_NEXT(a_s1_moves, s1_valid_r && s2_take, out_valid_r, "stage 1 item dropped")
  // a blocked input-stage item stays put
  `ASSERT_NEXT(a_s1_holds, s1_valid_r && !s2_take, s1_valid_r && $stable(s1_x_r),
               "stalled stage 1 item changed")
  // never accept while both stages are full and the result is stalled
  `ASSERT_PROP(a_no_overrun, !(in_ch.ready && s1_valid_r && out_valid_r && !out_ch.ready),
               "input accepted into a full pipe")

endmodule
